[rtl/core/bse_pkg.sv]
// Shared types, widths, curve tables and codes for the battery state-of-charge estimator.
package bse_pkg;

	// Number of points on the open-circuit-voltage curve.
	localparam int TABLE_ENTRIES = 30;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);

	// Field and register widths.
	localparam int MV_W = 18;
	localparam int CUR_W = 20;
	localparam int MS_W = 16;
	localparam int SOC_W = 17;
	localparam int SER_W = 6;
	localparam int PAR_W = 7;
	localparam int CAP_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// Internal arithmetic widths.
	localparam int UV_W = 22;          // per-cell curve point in microvolts
	localparam int K_W = 8;            // curve charge in 199ths
	localparam int V_W = 28;           // pack voltage and scaled points in microvolts
	localparam int CF_W = 33;          // Q32 charge fraction, 0 .. 2^32
	localparam int QUO_W = 32;         // divider quotient bits
	localparam int NUM_W = 36;         // largest dividend
	localparam int DEN_W = 45;         // largest divisor
	localparam int MA_W = 28;          // multiplier operand A
	localparam int MB_W = 22;          // multiplier operand B
	localparam int MP_W = MA_W + MB_W; // multiplier product

	localparam logic [K_W-1:0] SOC_DENOM = K_W'(199);
	localparam logic [MB_W-1:0] MS_PER_HOUR = MB_W'(3600000);
	localparam logic [CF_W-1:0] FULL_Q32 = {1'b1, {QUO_W{1'b0}}};

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_SERIES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PARALLEL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd2;

	// Input item kinds.
	localparam logic KIND_SEED = 1'b0;
	localparam logic KIND_COUNT = 1'b1;

	typedef logic [UV_W-1:0] uv_arr_t [TABLE_ENTRIES];
	typedef logic [K_W-1:0] k_arr_t [TABLE_ENTRIES];

	// Per-cell curve voltages in microvolts, rising strictly.
	localparam uv_arr_t CURVE_UV = '{
		22'd2704850, 22'd2807212, 22'd2884967, 22'd3000871, 22'd3081506,
		22'd3142881, 22'd3189041, 22'd3281106, 22'd3328019, 22'd3372405,
		22'd3424980, 22'd3497581, 22'd3555074, 22'd3597183, 22'd3661999,
		22'd3688721, 22'd3724416, 22'd3782435, 22'd3844352, 22'd3872892,
		22'd3933508, 22'd3962875, 22'd4034165, 22'd4058545, 22'd4071094,
		22'd4090083, 22'd4104695, 22'd4121874, 22'd4151565, 22'd4187750
	};

	// State of charge at each curve point, in units of 1/199.
	localparam k_arr_t CURVE_K = '{
		8'd0, 8'd1, 8'd2, 8'd4, 8'd6, 8'd8, 8'd10, 8'd15, 8'd18, 8'd22,
		8'd28, 8'd43, 8'd52, 8'd62, 8'd82, 8'd89, 8'd97, 8'd109, 8'd120, 8'd126,
		8'd142, 8'd148, 8'd160, 8'd165, 8'd169, 8'd182, 8'd188, 8'd192, 8'd196, 8'd199
	};

endpackage

[rtl/core/bse_ifs.sv]
// Handshake channel interfaces for the input item and the result of the estimator.
interface bse_item_if;
	logic valid;
	logic ready;
	logic kind;
	logic [17:0] pack_voltage_mv;
	logic signed [19:0] current_ma;
	logic [15:0] elapsed_ms;

	modport source (output valid, output kind, output pack_voltage_mv, output current_ma,
		output elapsed_ms, input ready);
	modport sink (input valid, input kind, input pack_voltage_mv, input current_ma,
		input elapsed_ms, output ready);
endinterface

interface bse_result_if;
	logic valid;
	logic ready;
	logic [16:0] soc_q16;

	modport source (output valid, output soc_q16, input ready);
	modport sink (input valid, input soc_q16, output ready);
endinterface

[rtl/core/battery_soc_estimator_core.sv]
// Top level of the battery state-of-charge estimator: sequencer, shared multiplier and state.
//
// The block tracks the pack state of charge as a Q32 fraction and returns it in Q16 after every
// input beat. A seed beat (kind 0) sets the charge from a rested pack voltage on a 30-point
// open-circuit-voltage curve scaled by the series cell count; below the curve it gives 0 and at
// or above the last point it gives full. A count beat (kind 1) removes current times elapsed
// time, or adds it for negative current, as a fraction of cell capacity times parallel cells,
// and saturates to 0..1. The block works on one beat at a time and holds item.ready low
// meanwhile. A seed beat checks the first and last curve points, stopping there below the
// curve or at or above its last point, then runs four or five binary search steps, scales
// the segment ends, forms the interpolation terms and divides. A count beat forms its step
// and divisor, divides unless one step drains or fills the pack outright, and applies the
// step. The work runs on the bit-serial divider and the one shared multiplier. The result
// register lets a new beat enter while the previous result still waits on result.ready.
// Configuration writes are taken at any edge with cfg_we high and must land while idle; a
// register written as zero acts as one.
module battery_soc_estimator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bse_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bse_pkg::CFG_DATA_W-1:0] cfg_wdata,
	bse_item_if.sink                      item,
	bse_result_if.source                  result
);
	import bse_pkg::*;

	// Sequencer states.
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_LOW   = 4'd1;
	localparam logic [3:0] ST_HIGH  = 4'd2;
	localparam logic [3:0] ST_SRCH  = 4'd3;
	localparam logic [3:0] ST_X1    = 4'd4;
	localparam logic [3:0] ST_X2    = 4'd5;
	localparam logic [3:0] ST_DEN   = 4'd6;
	localparam logic [3:0] ST_NUM1  = 4'd7;
	localparam logic [3:0] ST_NUM2  = 4'd8;
	localparam logic [3:0] ST_C1    = 4'd9;
	localparam logic [3:0] ST_C2    = 4'd10;
	localparam logic [3:0] ST_C3    = 4'd11;
	localparam logic [3:0] ST_GO    = 4'd12;
	localparam logic [3:0] ST_DIV   = 4'd13;
	localparam logic [3:0] ST_APPLY = 4'd14;
	localparam logic [3:0] ST_FIN   = 4'd15;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	// Configuration registers.
	logic [SER_W-1:0] series_q;
	logic [PAR_W-1:0] parallel_q;
	logic [CAP_W-1:0] capacity_q;
	logic [SER_W-1:0] ser_eff;
	logic [PAR_W-1:0] par_eff;
	logic [CAP_W-1:0] cap_eff;

	// Sequencer and working registers.
	logic [3:0]       state_q;
	logic [CF_W-1:0]  cf_q;
	logic             kind_q;
	logic [V_W-1:0]   v_q;
	logic             neg_q;
	logic [CUR_W-1:0] mag_q;
	logic [MS_W-1:0]  ms_q;
	logic [IDX_W-1:0] lo_q;
	logic [IDX_W-1:0] hi_q;
	logic [V_W-1:0]   x1_q;
	logic [V_W-1:0]   vx_q;
	logic [V_W-1:0]   dx_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [CF_W-1:0]  delta_q;
	logic             out_valid_q;
	logic [SOC_W-1:0] out_soc_q;

	// Shared multiplier.
	logic [MA_W-1:0] mul_a;
	logic [MB_W-1:0] mul_b;
	logic [MP_W-1:0] prod;
	logic [V_W-1:0]  pt;

	// Search helpers.
	logic [IDX_W:0]   mid_sum;
	logic [IDX_W-1:0] mid;
	logic [IDX_W-1:0] lo_p1;
	logic [IDX_W-1:0] lo_n;
	logic [IDX_W-1:0] hi_n;
	logic             pt_le_v;

	// Intake helpers.
	logic [V_W-1:0]   v_in;
	logic [CUR_W-1:0] cur_in;
	logic             accept;
	logic             load_out;

	// Charge update.
	logic [CF_W:0]   sum_up;

	// Divider link.
	logic             div_start;
	logic             div_done;
	logic [QUO_W-1:0] div_quo;

	assign ser_eff = (series_q == '0) ? SER_W'(1) : series_q;
	assign par_eff = (parallel_q == '0) ? PAR_W'(1) : parallel_q;
	assign cap_eff = (capacity_q == '0) ? CAP_W'(1) : capacity_q;

	assign accept = item.valid && item.ready;
	assign item.ready = (state_q == ST_IDLE);
	assign load_out = (state_q == ST_FIN) && (!out_valid_q || result.ready);

	// Millivolts to microvolts as a shift-and-subtract: 1000 = 1024 - 16 - 8.
	assign v_in = {item.pack_voltage_mv, 10'b0} - V_W'({item.pack_voltage_mv, 4'b0})
		- V_W'({item.pack_voltage_mv, 3'b0});
	assign cur_in = item.current_ma;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid = mid_sum[IDX_W:1];
	assign lo_p1 = lo_q + IDX_W'(1);

	// Operand selection for the one multiplier, by sequencer step.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_LOW: begin
				mul_a = MA_W'(CURVE_UV[0]);
				mul_b = MB_W'(ser_eff);
			end
			ST_HIGH: begin
				mul_a = MA_W'(CURVE_UV[LAST_IDX]);
				mul_b = MB_W'(ser_eff);
			end
			ST_SRCH: begin
				mul_a = MA_W'(CURVE_UV[mid]);
				mul_b = MB_W'(ser_eff);
			end
			ST_X1: begin
				mul_a = MA_W'(CURVE_UV[lo_q]);
				mul_b = MB_W'(ser_eff);
			end
			ST_X2: begin
				mul_a = MA_W'(CURVE_UV[lo_p1]);
				mul_b = MB_W'(ser_eff);
			end
			ST_DEN: begin
				mul_a = MA_W'(dx_q);
				mul_b = MB_W'(SOC_DENOM);
			end
			ST_NUM1: begin
				mul_a = MA_W'(dx_q);
				mul_b = MB_W'(CURVE_K[lo_q]);
			end
			ST_NUM2: begin
				mul_a = MA_W'(vx_q);
				mul_b = MB_W'(K_W'(CURVE_K[lo_p1] - CURVE_K[lo_q]));
			end
			ST_C1: begin
				mul_a = MA_W'(mag_q);
				mul_b = MB_W'(ms_q);
			end
			ST_C2: begin
				mul_a = MA_W'(cap_eff);
				mul_b = MB_W'(par_eff);
			end
			ST_C3: begin
				mul_a = den_q[MA_W-1:0];
				mul_b = MS_PER_HOUR;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = MP_W'(mul_a) * MP_W'(mul_b);
	// A scaled curve point always fits the voltage width.
	assign pt = prod[V_W-1:0];
	assign pt_le_v = (pt <= v_q);

	// One binary search step keeps point(lo) <= v < point(hi).
	always_comb begin
		lo_n = lo_q;
		hi_n = hi_q;
		if (pt_le_v) begin
			lo_n = mid;
		end else begin
			hi_n = mid;
		end
	end

	assign sum_up = {1'b0, cf_q} + {1'b0, delta_q};
	assign div_start = (state_q == ST_GO);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			series_q <= SER_W'(1);
			parallel_q <= PAR_W'(1);
			capacity_q <= CAP_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SERIES:   series_q <= cfg_wdata[SER_W-1:0];
				CFG_PARALLEL: parallel_q <= cfg_wdata[PAR_W-1:0];
				CFG_CAPACITY: capacity_q <= cfg_wdata[CAP_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and the charge state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cf_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (item.kind == KIND_SEED) ? ST_LOW : ST_C1;
					end
				end
				ST_LOW: begin
					if (!pt_le_v) begin
						cf_q <= '0;
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_HIGH;
					end
				end
				ST_HIGH: begin
					if (pt_le_v) begin
						cf_q <= FULL_Q32;
						state_q <= ST_FIN;
					end else begin
						state_q <= (TABLE_ENTRIES > 2) ? ST_SRCH : ST_X1;
					end
				end
				ST_SRCH: begin
					if (lo_n + IDX_W'(1) == hi_n) begin
						state_q <= ST_X1;
					end
				end
				ST_X1:   state_q <= ST_X2;
				ST_X2:   state_q <= ST_DEN;
				ST_DEN:  state_q <= ST_NUM1;
				ST_NUM1: state_q <= ST_NUM2;
				ST_NUM2: state_q <= ST_GO;
				ST_C1:   state_q <= ST_C2;
				ST_C2:   state_q <= ST_C3;
				ST_C3: begin
					// A step of a full pack or more skips the divider.
					if ({{(MP_W-NUM_W){1'b0}}, num_q} >= prod) begin
						state_q <= ST_APPLY;
					end else begin
						state_q <= ST_GO;
					end
				end
				ST_GO: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						if (kind_q == KIND_SEED) begin
							cf_q <= {1'b0, div_quo};
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_APPLY;
						end
					end
				end
				ST_APPLY: begin
					if (neg_q) begin
						cf_q <= (sum_up > {1'b0, FULL_Q32}) ? FULL_Q32 : sum_up[CF_W-1:0];
					end else begin
						cf_q <= (delta_q >= cf_q) ? '0 : CF_W'(cf_q - delta_q);
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working registers carry no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					kind_q <= item.kind;
					v_q <= v_in;
					neg_q <= cur_in[CUR_W-1];
					mag_q <= cur_in[CUR_W-1] ? CUR_W'(~cur_in + CUR_W'(1)) : cur_in;
					ms_q <= item.elapsed_ms;
				end
			end
			ST_HIGH: begin
				lo_q <= '0;
				hi_q <= LAST_IDX;
			end
			ST_SRCH: begin
				lo_q <= lo_n;
				hi_q <= hi_n;
			end
			ST_X1: begin
				x1_q <= pt;
				vx_q <= v_q - pt;
			end
			ST_X2:   dx_q <= pt - x1_q;
			ST_DEN:  den_q <= prod[DEN_W-1:0];
			ST_NUM1: num_q <= prod[NUM_W-1:0];
			ST_NUM2: num_q <= num_q + prod[NUM_W-1:0];
			ST_C1:   num_q <= prod[NUM_W-1:0];
			ST_C2:   den_q <= prod[DEN_W-1:0];
			ST_C3: begin
				den_q <= prod[DEN_W-1:0];
				delta_q <= FULL_Q32;
			end
			ST_DIV: begin
				if (div_done) begin
					delta_q <= {1'b0, div_quo};
				end
			end
			ST_FIN: begin
				if (load_out) begin
					out_soc_q <= cf_q[CF_W-1:CF_W-SOC_W];
				end
			end
			default: ;
		endcase
	end

	bse_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (DEN_W'(num_q)),
		.den    (den_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign result.valid = out_valid_q;
	assign result.soc_q16 = out_soc_q;

endmodule

[rtl/core/bse_div.sv]
// Restoring divider giving floor(num * 2^32 / den) one quotient bit per cycle, for num < den.
module bse_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [bse_pkg::DEN_W-1:0] num,
	input  logic [bse_pkg::DEN_W-1:0] den,
	output logic                      done,
	output logic [bse_pkg::QUO_W-1:0] quo
);
	import bse_pkg::*;

	localparam int CNT_W = $clog2(QUO_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [QUO_W-1:0] quo_q;
	logic [DEN_W:0]   rem_sh;
	logic             take;

	// The remainder stays below the divisor, so its doubled value fits one extra bit.
	assign rem_sh = {rem_q, 1'b0};
	assign take = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(QUO_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			if (take) begin
				rem_q <= DEN_W'(rem_sh - {1'b0, den_q});
			end else begin
				rem_q <= rem_sh[DEN_W-1:0];
			end
			quo_q <= {quo_q[QUO_W-2:0], take};
		end
	end

	assign done = done_q;
	assign quo = quo_q;

endmodule

[rtl/core/bse_checker.sv]
// Port-level checker for the battery state-of-charge estimator and its bind.
module bse_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [16:0] soc_q16
);

	// The state of charge never exceeds full.
	a_soc_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> soc_q16 <= 17'd65536)
		else $error("soc_q16 above full scale");

	// One beat at a time: the block is busy right after taking a beat.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("ready stayed high after an accepted beat");

	// A result cannot appear in the cycle right after a beat is accepted.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !$rose(out_valid))
		else $error("result appeared too early");

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(soc_q16)))
		else $error("stalled result changed");

endmodule

bind battery_soc_estimator_core bse_checker u_bse_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.soc_q16   (result.soc_q16)
);

[tb/tb.sv]
// Self-checking testbench for the battery state-of-charge estimator core.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bse_pkg::*;

	// Cycles with no beat on either channel before the run is declared hung.
	localparam int IDLE_LIMIT = 2000;
	// Cycles allowed after the last result for any stray beat to show up.
	localparam int SETTLE_CYCLES = 64;
	// Length of the one long receiver hold-off that fills the block.
	localparam int HOLD_CYCLES = 400;
	localparam int N_DIRECTED = 22;
	localparam int N_PHASES = 8;
	localparam int BEATS_PER_PHASE = 50;
	localparam logic [63:0] MS_HOUR = 64'd3600000;

	// Per-cell open-circuit-voltage curve in microvolts and the charge at each point in 199ths.
	localparam int unsigned OCV_POINT_UV [TABLE_ENTRIES] = '{
		2704850, 2807212, 2884967, 3000871, 3081506,
		3142881, 3189041, 3281106, 3328019, 3372405,
		3424980, 3497581, 3555074, 3597183, 3661999,
		3688721, 3724416, 3782435, 3844352, 3872892,
		3933508, 3962875, 4034165, 4058545, 4071094,
		4090083, 4104695, 4121874, 4151565, 4187750
	};
	localparam int unsigned OCV_POINT_K [TABLE_ENTRIES] = '{
		0, 1, 2, 4, 6, 8, 10, 15, 18, 22,
		28, 43, 52, 62, 82, 89, 97, 109, 120, 126,
		142, 148, 160, 165, 169, 182, 188, 192, 196, 199
	};

	// One row of the directed stimulus. When pinned is set the expected state of charge is
	// the one typed in the row; otherwise it comes from the charge predictor.
	typedef struct packed {
		logic kind;
		logic [MV_W-1:0] mv;
		logic signed [CUR_W-1:0] cur;
		logic [MS_W-1:0] ms;
		logic pinned;
		logic [SOC_W-1:0] soc;
	} stim_row_t;

	localparam logic [SOC_W-1:0] SOC_EMPTY = 17'd0;
	localparam logic [SOC_W-1:0] SOC_FULL = 17'd65536;

	stim_row_t directed_rows [N_DIRECTED] = '{
		// Counting before any seed starts from an empty pack and cannot go below it.
		'{KIND_COUNT, 18'd0, 20'sd0, 16'd0, 1'b1, SOC_EMPTY},
		'{KIND_COUNT, 18'd0, 20'sd1000, 16'd1000, 1'b1, SOC_EMPTY},
		'{KIND_COUNT, 18'd0, -20'sd1, 16'd1, 1'b0, SOC_EMPTY},
		// Seeds below the first curve point give an empty pack; seeds just inside the curve follow.
		'{KIND_SEED, 18'd0, 20'sd0, 16'd0, 1'b1, SOC_EMPTY},
		'{KIND_SEED, 18'd2704, 20'sd0, 16'd0, 1'b1, SOC_EMPTY},
		'{KIND_SEED, 18'd2705, 20'sd0, 16'd0, 1'b0, SOC_EMPTY},
		'{KIND_SEED, 18'd4187, 20'sd0, 16'd0, 1'b0, SOC_EMPTY},
		// At or above the last point the pack reads full.
		'{KIND_SEED, 18'd4188, 20'sd0, 16'd0, 1'b1, SOC_FULL},
		'{KIND_SEED, 18'd262143, 20'sd0, 16'd0, 1'b1, SOC_FULL},
		// Huge steps saturate at full and at empty.
		'{KIND_COUNT, 18'd0, 20'sh80000, 16'd65535, 1'b1, SOC_FULL},
		'{KIND_COUNT, 18'd0, 20'sd524287, 16'd65535, 1'b1, SOC_EMPTY},
		'{KIND_COUNT, 18'd0, 20'sh80000, 16'd65535, 1'b1, SOC_FULL},
		// No current or no time leaves the charge alone; a tiny drain step follows.
		'{KIND_COUNT, 18'd0, 20'sd0, 16'd65535, 1'b1, SOC_FULL},
		'{KIND_COUNT, 18'd0, 20'sd524287, 16'd0, 1'b1, SOC_FULL},
		'{KIND_COUNT, 18'd0, 20'sd1, 16'd1, 1'b0, SOC_EMPTY},
		// The unused fields of each kind carry junk and must be ignored.
		'{KIND_SEED, 18'd3600, 20'sh80000, 16'd65535, 1'b0, SOC_EMPTY},
		// Drawing exactly one full pack capacity empties it.
		'{KIND_COUNT, 18'd262143, 20'sd3600, 16'd1000, 1'b1, SOC_EMPTY},
		'{KIND_SEED, 18'd3400, 20'sd0, 16'd0, 1'b0, SOC_EMPTY},
		'{KIND_COUNT, 18'd0, -20'sd3599, 16'd1000, 1'b0, SOC_EMPTY},
		'{KIND_SEED, 18'd2807, 20'sd0, 16'd0, 1'b0, SOC_EMPTY},
		'{KIND_SEED, 18'd3000, 20'sd0, 16'd0, 1'b0, SOC_EMPTY},
		'{KIND_COUNT, 18'd0, -20'sd2, 16'd65535, 1'b0, SOC_EMPTY}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	bse_item_if item_ch ();
	bse_result_if result_ch ();

	battery_soc_estimator_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.item      (item_ch),
		.result    (result_ch)
	);

	// Shadow copy of the register file and the Q32 charge, as the block should hold them.
	logic [SER_W-1:0] series_raw;
	logic [PAR_W-1:0] parallel_raw;
	logic [CAP_W-1:0] capacity_raw;
	logic [CF_W-1:0] charge_q32;

	// Expected state-of-charge values, oldest first, and bookkeeping.
	logic [SOC_W-1:0] soc_pending [$];
	int beats_sent;
	int results_checked;
	int mismatch_count;
	int idle_cycles;
	int burst_left;
	bit hold_req;

	// Typed expectation that travels with the beat on offer.
	logic pin_en;
	logic [SOC_W-1:0] pin_soc;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Charge after one beat. A seed interpolates on the curve scaled by the series count;
	// a count step removes floor(2^32 * |I| * t / (cap * par * 3600000)) and saturates.
	function automatic logic [CF_W-1:0] charge_after(input logic kind, input logic [MV_W-1:0] mv,
			input logic signed [CUR_W-1:0] cur, input logic [MS_W-1:0] ms);
		logic [63:0] ser, par, cap, v, x1, dx, k1, k2, num, mag, n, d;
		logic [127:0] wide;
		logic [CF_W-1:0] delta;
		int seg;
		ser = (series_raw == '0) ? 64'd1 : 64'(series_raw);
		par = (parallel_raw == '0) ? 64'd1 : 64'(parallel_raw);
		cap = (capacity_raw == '0) ? 64'd1 : 64'(capacity_raw);
		if (kind == KIND_SEED) begin
			v = 64'(mv) * 64'd1000;
			if (v < 64'(OCV_POINT_UV[0]) * ser)
				return '0;
			seg = 0;
			for (int i = 1; i < TABLE_ENTRIES; i++)
				if (64'(OCV_POINT_UV[i]) * ser <= v)
					seg = i;
			if (seg == TABLE_ENTRIES - 1)
				return FULL_Q32;
			x1 = 64'(OCV_POINT_UV[seg]) * ser;
			dx = 64'(OCV_POINT_UV[seg + 1]) * ser - x1;
			k1 = 64'(OCV_POINT_K[seg]);
			k2 = 64'(OCV_POINT_K[seg + 1]);
			num = k1 * dx + (k2 - k1) * (v - x1);
			wide = {64'd0, num} << 32;
			return CF_W'(wide / {64'd0, 64'd199 * dx});
		end
		// Magnitude of the 20-bit two's complement current, 2^19 for the most negative code.
		mag = cur[CUR_W-1] ? (64'd1048576 - 64'({1'b0, cur})) : 64'({1'b0, cur});
		n = mag * 64'(ms);
		d = cap * par * MS_HOUR;
		if (n >= d) begin
			delta = FULL_Q32;
		end else begin
			wide = {64'd0, n} << 32;
			delta = CF_W'(wide / {64'd0, d});
		end
		// Negative current charges the pack, positive current drains it.
		if (cur[CUR_W-1])
			return (34'(charge_q32) + 34'(delta) > 34'(FULL_Q32)) ? FULL_Q32 : charge_q32 + delta;
		return (delta >= charge_q32) ? '0 : charge_q32 - delta;
	endfunction

	task automatic report_mismatch(input string what, input logic [SOC_W-1:0] want,
			input logic [SOC_W-1:0] got);
		$display("%0t: MISMATCH %s: expected soc_q16 %0d, got %0d", $realtime, what, want, got);
		mismatch_count++;
	endtask

	// Monitor: shadows register writes, predicts every accepted item beat and checks every
	// accepted result beat against the oldest expectation. Everything is sampled at the
	// rising edge, before any update scheduled at that edge takes effect.
	always @(posedge clk) begin : monitor
		logic [SOC_W-1:0] want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SERIES: series_raw = cfg_wdata[SER_W-1:0];
					CFG_PARALLEL: parallel_raw = cfg_wdata[PAR_W-1:0];
					CFG_CAPACITY: capacity_raw = cfg_wdata[CAP_W-1:0];
					default: ;
				endcase
			end
			if (result_ch.valid && result_ch.ready) begin
				if (soc_pending.size() == 0) begin
					report_mismatch("result beat with nothing pending", '0, result_ch.soc_q16);
				end else begin
					want = soc_pending.pop_front();
					if (result_ch.soc_q16 !== want)
						report_mismatch("soc_q16", want, result_ch.soc_q16);
				end
				results_checked++;
			end
			if (item_ch.valid && item_ch.ready) begin
				charge_q32 = charge_after(item_ch.kind, item_ch.pack_voltage_mv,
					item_ch.current_ma, item_ch.elapsed_ms);
				want = pin_en ? pin_soc : charge_q32[CF_W-1:16];
				soc_pending.push_back(want);
			end
		end
	end

	// Watchdog: a run where no beat moves on either channel for too long has hung.
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $realtime, IDLE_LIMIT);
			$display("battery_soc_estimator_core test failed");
			$finish;
		end
	end

	// Result receiver: stalls on windows of random mode, from always ready to mostly
	// stalled. On request it holds off for a long stretch so the block backs up.
	initial begin : receiver
		int mode, mode_left;
		logic take;
		mode = 0;
		mode_left = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(10, 80);
			end
			mode_left--;
			case (mode)
				0: take = 1'b1;
				1: take = ($urandom_range(0, 3) != 0);
				2: take = 1'($urandom_range(0, 1));
				default: take = ($urandom_range(0, 7) == 0);
			endcase
			result_ch.ready <= take;
		end
	end

	// Offers one item beat and returns at the edge that accepts it. Beats go out in bursts
	// of random length; between bursts valid drops for a random gap, or none. Within a burst valid
	// stays high and only the payload changes.
	task automatic offer_beat(input logic kind, input logic [MV_W-1:0] mv,
			input logic signed [CUR_W-1:0] cur, input logic [MS_W-1:0] ms,
			input logic pinned, input logic [SOC_W-1:0] soc);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0
				: $urandom_range(1, ($urandom_range(0, 7) == 0) ? 60 : 8);
			if (gap > 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, ($urandom_range(0, 5) == 0) ? 40 : 10);
		end
		item_ch.valid <= 1'b1;
		item_ch.kind <= kind;
		item_ch.pack_voltage_mv <= mv;
		item_ch.current_ma <= cur;
		item_ch.elapsed_ms <= ms;
		pin_en <= pinned;
		pin_soc <= soc;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		beats_sent++;
		burst_left--;
	endtask

	// Stops offering and waits until every accepted beat has its result checked, so the
	// block is idle and safe to reconfigure.
	task automatic drain_results();
		item_ch.valid <= 1'b0;
		while (results_checked < beats_sent)
			@(posedge clk);
		repeat (4) @(posedge clk);
		burst_left = 0;
	endtask

	// Writes all three registers on consecutive edges; write enable drops after the last.
	task automatic program_settings(input logic [CFG_DATA_W-1:0] ser_w,
			input logic [CFG_DATA_W-1:0] par_w, input logic [CFG_DATA_W-1:0] cap_w);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SERIES;
		cfg_wdata <= ser_w;
		@(posedge clk);
		cfg_index <= CFG_PARALLEL;
		cfg_wdata <= par_w;
		@(posedge clk);
		cfg_index <= CFG_CAPACITY;
		cfg_wdata <= cap_w;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		logic [CFG_DATA_W-1:0] phase_cfg [N_PHASES][3];
		logic [MV_W-1:0] mv;
		logic signed [CUR_W-1:0] cur;
		logic [MS_W-1:0] ms;
		logic [CUR_W-1:0] mag;
		int n_beats, n_counts, ser, lo_mv, hi_mv, bits;

		series_raw = 6'd1;
		parallel_raw = 7'd1;
		capacity_raw = 16'd1;
		charge_q32 = '0;
		beats_sent = 0;
		results_checked = 0;
		mismatch_count = 0;
		idle_cycles = 0;
		burst_left = 0;
		hold_req = 1'b0;
		pin_en = 1'b0;
		pin_soc = '0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_SERIES;
		cfg_wdata = '0;
		item_ch.valid = 1'b0;
		item_ch.kind = KIND_SEED;
		item_ch.pack_voltage_mv = '0;
		item_ch.current_ma = '0;
		item_ch.elapsed_ms = '0;

		// Register settings per phase: the top of the allowed ranges, zeros that act as one,
		// every bit set (junk above each register's width), small packs and random ones.
		phase_cfg[0] = '{16'd32, 16'd64, 16'd65535};
		phase_cfg[1] = '{16'd0, 16'd0, 16'd0};
		phase_cfg[2] = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
		phase_cfg[3] = '{16'd1, 16'd1, 16'd65535};
		phase_cfg[4] = '{16'hFFC0, 16'hFF80, 16'd1};
		phase_cfg[5] = '{16'd12, 16'd4, 16'd2500};
		phase_cfg[6] = '{16'($urandom_range(1, 32)), 16'($urandom_range(1, 64)),
			16'($urandom_range(1, 65535))};
		phase_cfg[7] = '{16'($urandom), 16'($urandom), 16'($urandom)};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats run on the reset settings: one cell, 1 mAh.
		for (int r = 0; r < N_DIRECTED; r++)
			offer_beat(directed_rows[r].kind, directed_rows[r].mv, directed_rows[r].cur,
				directed_rows[r].ms, directed_rows[r].pinned, directed_rows[r].soc);
		drain_results();

		for (int p = 0; p < N_PHASES; p++) begin
			program_settings(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2]);
			ser = (phase_cfg[p][0][SER_W-1:0] == '0) ? 1 : int'(phase_cfg[p][0][SER_W-1:0]);
			// Pack voltage span of the scaled curve in millivolts.
			lo_mv = (2704850 * ser) / 1000;
			hi_mv = (4187750 * ser + 999) / 1000 + 2;
			if (hi_mv > 262143)
				hi_mv = 262143;
			// In the second phase the receiver stops for a long stretch while beats keep
			// coming, so the block fills and holds its input off.
			if (p == 1)
				hold_req = 1'b1;
			n_beats = 0;
			while (n_beats < BEATS_PER_PHASE) begin
				if ($urandom_range(0, 9) == 0) begin
					// Noise: any kind with every field random.
					offer_beat(1'($urandom), MV_W'($urandom), CUR_W'($urandom), MS_W'($urandom),
						1'b0, '0);
					n_beats++;
				end else begin
					// A seed, mostly on or near the curve, followed by a run of count steps.
					case ($urandom_range(0, 9))
						0: mv = MV_W'($urandom);
						1: mv = MV_W'(lo_mv + $urandom_range(0, 6) - 3);
						2: mv = MV_W'(hi_mv - $urandom_range(0, 5));
						default: mv = MV_W'($urandom_range(lo_mv, hi_mv));
					endcase
					offer_beat(KIND_SEED, mv, CUR_W'($urandom), MS_W'($urandom), 1'b0, '0);
					n_counts = $urandom_range(2, 8);
					repeat (n_counts) begin
						if ($urandom_range(0, 4) == 0) begin
							cur = CUR_W'($urandom);
						end else begin
							// Magnitudes spread over every scale from one mA up.
							bits = $urandom_range(0, 19);
							mag = CUR_W'($urandom_range(0, (1 << bits) - 1));
							cur = $urandom_range(0, 1) ? -$signed(mag) : $signed(mag);
						end
						ms = $urandom_range(0, 1) ? MS_W'($urandom) : MS_W'($urandom_range(0, 1000));
						offer_beat(KIND_COUNT, MV_W'($urandom), cur, ms, 1'b0, '0);
					end
					n_beats += 1 + n_counts;
				end
			end
			drain_results();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && soc_pending.size() == 0)
			$display("battery_soc_estimator_core test passed");
		else
			$display("battery_soc_estimator_core test failed");
		$finish;
	end

endmodule
